// ===== src/wbc_pkg.sv =====
// Package of the water block object classifier: verdict and register codes,
// configuration and queue types, and the divider step function.
// Depends on nothing; every other file of the block uses it.
package wbc_pkg;

    // Verdict codes of a result.
    typedef enum logic [2:0] {
        V_OBJECT = 3'd0,
        V_BLUISH = 3'd1,
        V_PALE   = 3'd2,
        V_DARK   = 3'd3,
        V_LOW    = 3'd4
    } t_verdict;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_HUE_MEAN   = 3'd0,
        REG_HUE_SPREAD = 3'd1,
        REG_SAT_MEAN   = 3'd2,
        REG_SAT_SPREAD = 3'd3,
        REG_VAL_MEAN   = 3'd4,
        REG_VAL_SPREAD = 3'd5,
        REG_STRICT_THR = 3'd6,
        REG_RELAX_THR  = 3'd7
    } t_reg_idx;

    // Divider geometry: 40-bit numerator, 16-bit divisor, 24-bit quotient.
    localparam int DIV_QW     = 24;
    localparam int DIV_RW     = 16;
    localparam int DIV_NW     = DIV_QW + DIV_RW;
    localparam int DIV_STAGES = DIV_QW;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Color thresholds.
    localparam logic [7:0]  MIN_WHITE_V  = 8'd180;
    localparam logic [7:0]  MIN_SAT_S    = 8'd11;
    localparam logic [7:0]  DARK_V       = 8'd85;
    localparam logic [9:0]  FULL_SUM     = 10'd765;
    localparam logic [2:0]  BLUE_MARGIN  = 3'd5;
    localparam logic [15:0] SAT_FLOOR_FX = 16'd7680;

    typedef struct packed {
        logic [15:0] hue_mean;
        logic [15:0] hue_spread;
        logic [15:0] sat_mean;
        logic [15:0] sat_spread;
        logic [15:0] val_mean;
        logic [15:0] val_spread;
        logic [15:0] strict_thr;
        logic [15:0] relax_thr;
    } t_cfg;

    // One classified block as it travels from the front to the back.
    typedef struct packed {
        logic       mode;
        t_verdict   verdict;
        logic [7:0] sat;
        logic [7:0] hue;
        logic [7:0] val;
    } t_qent;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // One restoring division step: returns {remainder, shifted low bits}.
    function automatic logic [DIV_NW-1:0] div_step(input logic [DIV_RW-1:0] rem,
                                                   input logic [DIV_QW-1:0] low,
                                                   input logic [DIV_RW-1:0] den);
        logic [DIV_RW:0]   trial;
        logic [DIV_RW:0]   diff;
        logic              q;
        logic [DIV_RW-1:0] nrem;
        trial = {rem, low[DIV_QW-1]};
        diff  = trial - {1'b0, den};
        q     = (trial >= {1'b0, den});
        nrem  = q ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
        return {nrem, low[DIV_QW-2:0], q};
    endfunction

endpackage

// ===== src/wbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on wbc_pkg for its geometry and step function.
module wbc_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [wbc_pkg::DIV_NW-1:0]    i_num,
    input  logic [wbc_pkg::DIV_RW-1:0]    i_den,
    output logic [wbc_pkg::DIV_QW-1:0]    o_quot
);

    logic [wbc_pkg::DIV_RW-1:0] r_rem [wbc_pkg::DIV_STAGES];
    logic [wbc_pkg::DIV_QW-1:0] r_low [wbc_pkg::DIV_STAGES];
    logic [wbc_pkg::DIV_RW-1:0] r_den [wbc_pkg::DIV_STAGES];

    // Each stage takes one numerator bit into the remainder.
    for (genvar k = 0; k < wbc_pkg::DIV_STAGES; k++) begin : g_stage
        logic [wbc_pkg::DIV_NW-1:0] n_step;
        if (k == 0) begin : g_first
            assign n_step = wbc_pkg::div_step(i_num[wbc_pkg::DIV_NW-1:wbc_pkg::DIV_QW],
                                              i_num[wbc_pkg::DIV_QW-1:0], i_den);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= i_den;
                end
            end
        end else begin : g_next
            assign n_step = wbc_pkg::div_step(r_rem[k-1], r_low[k-1], r_den[k-1]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_step[wbc_pkg::DIV_NW-1:wbc_pkg::DIV_QW];
                r_low[k] <= n_step[wbc_pkg::DIV_QW-1:0];
            end
        end
    end

    assign o_quot = r_low[wbc_pkg::DIV_STAGES-1];

endmodule

// ===== src/wbc_front.sv =====
// Front of the classifier: takes a block color, finds hue, saturation and
// value, and decides the early rejects. Depends on wbc_pkg and wbc_div.
module wbc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_red,
    input  logic [7:0]     i_green,
    input  logic [7:0]     i_blue,
    input  logic           i_mode,
    input  wbc_pkg::t_qstat i_qstat,
    output logic           o_push,
    output wbc_pkg::t_qent o_ent
);

    typedef struct packed {
        logic       mode;
        logic       bluish;
        logic [7:0] val;
    } t_fside;

    logic       en;
    logic       r_f0_valid;
    logic [7:0] r_red, r_green, r_blue;
    logic       r_mode;
    logic [wbc_pkg::DIV_STAGES-1:0] r_valid;
    t_fside     r_side [wbc_pkg::DIV_STAGES];

    logic [7:0]  mx, mn, d;
    logic [9:0]  sum;
    logic [17:0] lhs_g, lhs_r, rhs;
    logic        bluish;
    logic [15:0] t, sat_num;
    logic [15:0] sat_den, hue_den;
    logic [wbc_pkg::DIV_QW-1:0] sat_q, hue_q;
    t_fside      last;

    // The front moves unless its finished item cannot enter the queue.
    assign en      = !r_valid[wbc_pkg::DIV_STAGES-1] || !i_qstat.full;
    assign o_stall = !en;
    assign o_push  = r_valid[wbc_pkg::DIV_STAGES-1] && !i_qstat.full;

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
        end else if (en) begin
            r_f0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_mode  <= i_mode;
        end
    end

    // Extremes, the bluish test and the hue numerator.
    always_comb begin
        mx = (r_red > r_green) ? r_red : r_green;
        if (r_blue > mx) mx = r_blue;
        mn = (r_red < r_green) ? r_red : r_green;
        if (r_blue < mn) mn = r_blue;
        d   = mx - mn;
        sum = 10'(r_red) + 10'(r_green) + 10'(r_blue);

        lhs_g  = 18'(wbc_pkg::FULL_SUM) * 18'(r_blue - r_green);
        lhs_r  = 18'(wbc_pkg::FULL_SUM) * 18'(r_blue - r_red);
        rhs    = 18'(wbc_pkg::BLUE_MARGIN) * 18'(sum);
        bluish = (sum != 10'd0) && (r_blue > r_green) && (r_blue > r_red)
                 && (lhs_g >= rhs) && (lhs_r >= rhs);

        if (r_red == mx) begin
            if (r_green >= r_blue) t = 16'd30 * 16'(r_green - r_blue);
            else t = 16'd180 * 16'(d) - 16'd30 * 16'(r_blue - r_green);
        end else if (r_green == mx) begin
            if (r_blue >= r_red) t = 16'd60 * 16'(d) + 16'd30 * 16'(r_blue - r_red);
            else t = 16'd60 * 16'(d) - 16'd30 * 16'(r_red - r_blue);
        end else begin
            if (r_red >= r_green) t = 16'd120 * 16'(d) + 16'd30 * 16'(r_red - r_green);
            else t = 16'd120 * 16'(d) - 16'd30 * 16'(r_green - r_red);
        end

        sat_num = 16'd255 * 16'(d);
        sat_den = (mx == 8'd0) ? 16'd1 : 16'(mx);
        hue_den = (d == 8'd0) ? 16'd1 : 16'(d);
    end

    wbc_div u_sat_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (wbc_pkg::DIV_NW'(sat_num)),
        .i_den  (sat_den),
        .o_quot (sat_q)
    );

    wbc_div u_hue_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (wbc_pkg::DIV_NW'(t)),
        .i_den  (hue_den),
        .o_quot (hue_q)
    );

    // Side data travels beside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[wbc_pkg::DIV_STAGES-2:0], r_f0_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{mode: r_mode, bluish: bluish, val: mx};
            for (int k = 1; k < wbc_pkg::DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Early verdict: bluish, then pale in strict mode, then dark.
    always_comb begin
        last        = r_side[wbc_pkg::DIV_STAGES-1];
        o_ent.mode  = last.mode;
        o_ent.sat   = sat_q[7:0];
        o_ent.hue   = hue_q[7:0];
        o_ent.val   = last.val;
        if (last.bluish) begin
            o_ent.verdict = wbc_pkg::V_BLUISH;
        end else if (!last.mode && sat_q[7:0] <= wbc_pkg::MIN_SAT_S
                     && last.val < wbc_pkg::MIN_WHITE_V) begin
            o_ent.verdict = wbc_pkg::V_PALE;
        end else if (last.val < wbc_pkg::DARK_V) begin
            o_ent.verdict = wbc_pkg::V_DARK;
        end else begin
            o_ent.verdict = wbc_pkg::V_OBJECT;
        end
    end

endmodule

// ===== src/wbc_queue.sv =====
// Short queue of classified blocks between the front and the back.
// Depends on wbc_pkg for the entry type and depth.
module wbc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wbc_pkg::t_qent  i_ent,
    input  logic            i_pop,
    output wbc_pkg::t_qent  o_ent,
    output wbc_pkg::t_qstat o_qstat
);

    wbc_pkg::t_qent        r_mem [wbc_pkg::QDEPTH];
    logic [wbc_pkg::QAW-1:0] r_wptr, r_rptr;
    logic [wbc_pkg::QAW:0]   r_count;

    assign o_qstat.full  = (r_count == (wbc_pkg::QAW+1)'(wbc_pkg::QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_ent         = r_mem[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_ent;
    end

endmodule

// ===== src/wbc_back.sv =====
// Back of the classifier: deviation score, hue damping, threshold test and
// the output register. Depends on wbc_pkg and wbc_div.
module wbc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wbc_pkg::t_cfg   i_cfg,
    input  wbc_pkg::t_qstat i_qstat,
    input  wbc_pkg::t_qent  i_ent,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic            o_is_object,
    output logic [2:0]      o_verdict,
    output logic [15:0]     o_score
);

    typedef struct packed {
        logic              mode;
        wbc_pkg::t_verdict verdict;
        logic [15:0]       sf;
    } t_bside1;

    typedef struct packed {
        logic              mode;
        wbc_pkg::t_verdict verdict;
        logic [23:0]       qh;
        logic [24:0]       qsv;
        logic              damp;
    } t_bside2;

    logic en;
    logic r_b0_valid;
    wbc_pkg::t_qent r_b0;

    logic [wbc_pkg::DIV_STAGES-1:0] r_v1, r_v2;
    t_bside1 r_s1 [wbc_pkg::DIV_STAGES];
    t_bside2 r_s2 [wbc_pkg::DIV_STAGES];

    logic [15:0] dh, ds, dv, hden, sden, vden, f;
    logic [wbc_pkg::DIV_QW-1:0] qh, qs, qv, qd;

    logic              r_m_valid;
    logic              r_m_mode;
    wbc_pkg::t_verdict r_m_verdict;
    logic [23:0]       r_m_qh;
    logic [24:0]       r_m_qsv;
    logic              r_m_damp;
    logic [39:0]       r_m_prod;

    t_bside2     last;
    logic [23:0] qhd;
    logic [25:0] total;
    logic [15:0] score, thr;

    // The back moves when the output register is free or being emptied.
    assign en    = !o_valid || !i_stall;
    assign o_pop = en && !i_qstat.empty;

    // Head of the back pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid <= 1'b0;
        end else if (en) begin
            r_b0_valid <= !i_qstat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_b0 <= i_ent;
    end

    // Absolute deviations from the water means and the spread divisors.
    function automatic logic [15:0] absdiff(input logic [7:0] x, input logic [15:0] m);
        logic [15:0] xf;
        xf = {x, 8'd0};
        return (xf >= m) ? (xf - m) : (m - xf);
    endfunction

    always_comb begin
        dh   = absdiff(r_b0.hue, i_cfg.hue_mean);
        ds   = absdiff(r_b0.sat, i_cfg.sat_mean);
        dv   = absdiff(r_b0.val, i_cfg.val_mean);
        hden = (i_cfg.hue_spread == 16'd0) ? 16'd1 : i_cfg.hue_spread;
        sden = (i_cfg.sat_spread == 16'd0) ? 16'd1 : i_cfg.sat_spread;
        vden = (i_cfg.val_spread == 16'd0) ? 16'd1 : i_cfg.val_spread;
        f    = (i_cfg.sat_mean > wbc_pkg::SAT_FLOOR_FX) ? i_cfg.sat_mean
                                                         : wbc_pkg::SAT_FLOOR_FX;
    end

    wbc_div u_hue_dev (.i_clk(i_clk), .i_en(en),
                       .i_num({16'd0, dh, 8'd0}), .i_den(hden), .o_quot(qh));
    wbc_div u_sat_dev (.i_clk(i_clk), .i_en(en),
                       .i_num({16'd0, ds, 8'd0}), .i_den(sden), .o_quot(qs));
    wbc_div u_val_dev (.i_clk(i_clk), .i_en(en),
                       .i_num({16'd0, dv, 8'd0}), .i_den(vden), .o_quot(qv));

    // Side data beside the deviation dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= '0;
        end else if (en) begin
            r_v1 <= {r_v1[wbc_pkg::DIV_STAGES-2:0], r_b0_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= '{mode: r_b0.mode, verdict: r_b0.verdict, sf: {r_b0.sat, 8'd0}};
            for (int k = 1; k < wbc_pkg::DIV_STAGES; k++) begin
                r_s1[k] <= r_s1[k-1];
            end
        end
    end

    // Damping product and the sum of the other two terms.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_v1[wbc_pkg::DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_mode    <= r_s1[wbc_pkg::DIV_STAGES-1].mode;
            r_m_verdict <= r_s1[wbc_pkg::DIV_STAGES-1].verdict;
            r_m_qh      <= qh;
            r_m_qsv     <= 25'(qs) + 25'(qv);
            r_m_damp    <= (r_s1[wbc_pkg::DIV_STAGES-1].sf < f);
            r_m_prod    <= 40'(qh) * 40'(r_s1[wbc_pkg::DIV_STAGES-1].sf);
        end
    end

    wbc_div u_damp_div (.i_clk(i_clk), .i_en(en),
                        .i_num(r_m_prod), .i_den(f), .o_quot(qd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= '0;
        end else if (en) begin
            r_v2 <= {r_v2[wbc_pkg::DIV_STAGES-2:0], r_m_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2[0] <= '{mode: r_m_mode, verdict: r_m_verdict, qh: r_m_qh,
                         qsv: r_m_qsv, damp: r_m_damp};
            for (int k = 1; k < wbc_pkg::DIV_STAGES; k++) begin
                r_s2[k] <= r_s2[k-1];
            end
        end
    end

    // Saturated score and the threshold of the mode.
    always_comb begin
        last  = r_s2[wbc_pkg::DIV_STAGES-1];
        qhd   = last.damp ? qd : last.qh;
        total = 26'(qhd) + 26'(last.qsv);
        score = (total[25:16] != 10'd0) ? 16'hFFFF : total[15:0];
        thr   = last.mode ? i_cfg.relax_thr : i_cfg.strict_thr;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_v2[wbc_pkg::DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (last.verdict != wbc_pkg::V_OBJECT) begin
                o_verdict   <= last.verdict;
                o_score     <= 16'd0;
                o_is_object <= 1'b0;
            end else begin
                o_verdict   <= (score >= thr) ? wbc_pkg::V_OBJECT : wbc_pkg::V_LOW;
                o_score     <= score;
                o_is_object <= (score >= thr);
            end
        end
    end

endmodule

// ===== src/water_block_object_classifier.sv =====
// Top level of the water block object classifier: configuration registers,
// front, queue and back. Depends on wbc_pkg, wbc_front, wbc_queue, wbc_back.
//
// Use: a block color request (i_red, i_green, i_blue, i_mode) is taken at a
// rising edge with i_valid high and o_stall low. Its result (o_is_object,
// o_verdict, o_score) is offered with o_valid and taken when i_stall is low.
// Results leave in request order, one for each request.
// Throughput: one request per cycle while o_stall is low (fully pipelined dividers).
// Path from acceptance to o_valid: the front (input stage and hue/saturation
// dividers), the queue, and the back (head register, deviation dividers,
// product stage, damping divider and output register).
// When the receiver stalls, the back holds and the front keeps taking
// requests until its four-entry queue is full; then o_stall rises.
// Reset (synchronous, active low) empties the pipelines and the queue and
// loads the register defaults. Configuration must be written through the APB
// port only while no request is in flight; the block does not enforce this.
module water_block_object_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_mode,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_object,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_score,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    wbc_pkg::t_cfg    r_cfg;
    wbc_pkg::t_qstat  qstat;
    wbc_pkg::t_qent   push_ent, head_ent;
    wbc_pkg::t_reg_idx idx;
    logic push, pop, wr;

    assign pready = 1'b1;
    assign idx    = wbc_pkg::t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{hue_mean: 16'd0, hue_spread: 16'd256, sat_mean: 16'd0,
                       sat_spread: 16'd256, val_mean: 16'd0, val_spread: 16'd256,
                       strict_thr: 16'd256, relax_thr: 16'd256};
        end else if (wr) begin
            unique case (idx)
                wbc_pkg::REG_HUE_MEAN:   r_cfg.hue_mean   <= pwdata[15:0];
                wbc_pkg::REG_HUE_SPREAD: r_cfg.hue_spread <= pwdata[15:0];
                wbc_pkg::REG_SAT_MEAN:   r_cfg.sat_mean   <= pwdata[15:0];
                wbc_pkg::REG_SAT_SPREAD: r_cfg.sat_spread <= pwdata[15:0];
                wbc_pkg::REG_VAL_MEAN:   r_cfg.val_mean   <= pwdata[15:0];
                wbc_pkg::REG_VAL_SPREAD: r_cfg.val_spread <= pwdata[15:0];
                wbc_pkg::REG_STRICT_THR: r_cfg.strict_thr <= pwdata[15:0];
                wbc_pkg::REG_RELAX_THR:  r_cfg.relax_thr  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (idx)
            wbc_pkg::REG_HUE_MEAN:   prdata = {16'd0, r_cfg.hue_mean};
            wbc_pkg::REG_HUE_SPREAD: prdata = {16'd0, r_cfg.hue_spread};
            wbc_pkg::REG_SAT_MEAN:   prdata = {16'd0, r_cfg.sat_mean};
            wbc_pkg::REG_SAT_SPREAD: prdata = {16'd0, r_cfg.sat_spread};
            wbc_pkg::REG_VAL_MEAN:   prdata = {16'd0, r_cfg.val_mean};
            wbc_pkg::REG_VAL_SPREAD: prdata = {16'd0, r_cfg.val_spread};
            wbc_pkg::REG_STRICT_THR: prdata = {16'd0, r_cfg.strict_thr};
            wbc_pkg::REG_RELAX_THR:  prdata = {16'd0, r_cfg.relax_thr};
            default:                 prdata = 32'd0;
        endcase
    end

    wbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_mode  (i_mode),
        .i_qstat (qstat),
        .o_push  (push),
        .o_ent   (push_ent)
    );

    wbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .i_pop   (pop),
        .o_ent   (head_ent),
        .o_qstat (qstat)
    );

    wbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_qstat     (qstat),
        .i_ent       (head_ent),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_is_object (o_is_object),
        .o_verdict   (o_verdict),
        .o_score     (o_score)
    );

`ifndef ASSERT_OFF
    // The front never pushes into a full queue, and the back never pops an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty) else $error("queue pop while empty");
    // The object flag follows the verdict.
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_object == (o_verdict == wbc_pkg::V_OBJECT)))
        else $error("object flag disagrees with verdict");
    // Early rejects carry no score.
    a_early_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == wbc_pkg::V_BLUISH || o_verdict == wbc_pkg::V_PALE
                     || o_verdict == wbc_pkg::V_DARK)) |-> (o_score == 16'd0))
        else $error("early reject with nonzero score");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench of the water block object classifier: a directed table of colors,
// then random colors under several register settings, checked against a predictor.
// Depends on wbc_pkg and water_block_object_classifier.
`timescale 1ns / 100ps

module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        i_mode = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_is_object;
    logic [2:0]  o_verdict;
    logic [15:0] o_score;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    water_block_object_classifier dut (.*);

    always #10 i_clk = ~i_clk;

    // Expected classification of one block.
    typedef struct {
        logic              is_object;
        wbc_pkg::t_verdict verdict;
        logic [15:0]       score;
    } t_result;

    // Directed row: color, mode, and optional typed-in verdict.
    typedef struct {
        logic [7:0]        r, g, b;
        logic              mode;
        logic              fixed;
        wbc_pkg::t_verdict verdict;
    } t_row;

    logic [15:0] regs [8];
    t_result     pending_results [$];
    int          mismatches = 0;
    logic        quiet = 1'b0;

    // Deviation of one component from its water mean, scaled by the spread.
    function automatic logic [63:0] scaled_deviation(logic [31:0] x, logic [15:0] mean,
                                                     logic [15:0] spread);
        logic [63:0] xf, diff, sp;
        xf = {32'd0, x} << 8;
        diff = (xf >= mean) ? xf - mean : {48'd0, mean} - xf;
        sp = (spread == 0) ? 64'd1 : {48'd0, spread};
        return (diff << 8) / sp;
    endfunction

    function automatic t_result classify(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                         logic relaxed);
        t_result res;
        int r, g, b, sum, mx, mn, d, t, hue, sat;
        logic [63:0] qh, qs, qv, f, sf, total;
        logic [15:0] thr;
        r = r8; g = g8; b = b8;
        sum = r + g + b;
        res.is_object = 1'b0;
        res.score = '0;
        hue = 0; sat = 0;
        if (sum > 0 && 765 * (b - g) >= 5 * sum && 765 * (b - r) >= 5 * sum) begin
            res.verdict = wbc_pkg::V_BLUISH;
            return res;
        end
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (mx > 0) sat = (255 * d) / mx;
        if (d > 0) begin
            if (r >= mx) begin
                t = 30 * (g - b);
                if (t < 0) t += 180 * d;
            end else if (g >= mx) begin
                t = 60 * d + 30 * (b - r);
            end else begin
                t = 120 * d + 30 * (r - g);
            end
            hue = t / d;
        end
        if (!relaxed && sat <= 11 && mx < 180) begin
            res.verdict = wbc_pkg::V_PALE;
            return res;
        end
        if (mx < 85) begin
            res.verdict = wbc_pkg::V_DARK;
            return res;
        end
        qh = scaled_deviation(hue, regs[wbc_pkg::REG_HUE_MEAN], regs[wbc_pkg::REG_HUE_SPREAD]);
        qs = scaled_deviation(sat, regs[wbc_pkg::REG_SAT_MEAN], regs[wbc_pkg::REG_SAT_SPREAD]);
        qv = scaled_deviation(mx, regs[wbc_pkg::REG_VAL_MEAN], regs[wbc_pkg::REG_VAL_SPREAD]);
        f = (regs[wbc_pkg::REG_SAT_MEAN] > wbc_pkg::SAT_FLOOR_FX) ? regs[wbc_pkg::REG_SAT_MEAN]
                                                                   : wbc_pkg::SAT_FLOOR_FX;
        sf = sat << 8;
        if (sf < f) qh = (qh * sf) / f;
        total = qh + qs + qv;
        res.score = (total > 64'hFFFF) ? 16'hFFFF : total[15:0];
        thr = relaxed ? regs[wbc_pkg::REG_RELAX_THR] : regs[wbc_pkg::REG_STRICT_THR];
        res.verdict = (res.score >= thr) ? wbc_pkg::V_OBJECT : wbc_pkg::V_LOW;
        res.is_object = (res.verdict == wbc_pkg::V_OBJECT);
        return res;
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(wbc_pkg::t_reg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        regs[idx] = value;
    endtask

    // Present one request and wait for it to be taken.
    task automatic send_block(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic m);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= r; i_green <= g; i_blue <= b; i_mode <= m;
        pending_results.insert(pending_results.size(), classify(r, g, b, m));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // Receiver stall in random bursts.
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result verdict %0d", o_verdict);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_is_object !== want.is_object) begin
                    $error("is_object: expected %0d, got %0d", want.is_object, o_is_object);
                    mismatches++;
                end
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    mismatches++;
                end
                if (o_score !== want.score) begin
                    $error("score: expected %0d, got %0d", want.score, o_score);
                    mismatches++;
                end
            end
        end
    end

    // Sweep one register setting with random colors.
    task automatic random_phase(int count);
        logic [7:0] r, g, b;
        for (int k = 0; k < count; k++) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            send_block(r, g, b, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_settings(bit extremes);
        for (int i = 0; i < 8; i++) begin
            if (extremes)
                write_reg(wbc_pkg::t_reg_idx'(i),
                          ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
            else if (i == wbc_pkg::REG_HUE_MEAN)
                write_reg(wbc_pkg::t_reg_idx'(i), 16'($urandom_range(0, 180 * 256)));
            else if (i == wbc_pkg::REG_STRICT_THR || i == wbc_pkg::REG_RELAX_THR)
                write_reg(wbc_pkg::t_reg_idx'(i), 16'($urandom_range(0, 2048)));
            else
                write_reg(wbc_pkg::t_reg_idx'(i),
                          16'($urandom_range(1, 65535) >> $urandom_range(0, 8)));
        end
    endtask

    t_row directed [] = '{
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, wbc_pkg::V_PALE},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, wbc_pkg::V_DARK},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b1, wbc_pkg::V_BLUISH},
        '{8'd0,   8'd0,   8'd1,   1'b1, 1'b1, wbc_pkg::V_BLUISH},
        '{8'd100, 8'd100, 8'd101, 1'b1, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd170, 8'd170, 8'd170, 1'b0, 1'b1, wbc_pkg::V_PALE},
        '{8'd170, 8'd170, 8'd170, 1'b1, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd84,  8'd10,  8'd10,  1'b1, 1'b1, wbc_pkg::V_DARK},
        '{8'd85,  8'd10,  8'd10,  1'b1, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd255, 8'd0,   8'd10,  1'b0, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd0,   8'd255, 8'd0,   1'b1, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd0,   8'd200, 8'd255, 1'b1, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd179, 8'd178, 8'd177, 1'b0, 1'b1, wbc_pkg::V_PALE},
        '{8'd180, 8'd178, 8'd177, 1'b0, 1'b0, wbc_pkg::V_OBJECT},
        '{8'd200, 8'd100, 8'd255, 1'b1, 1'b0, wbc_pkg::V_OBJECT}
    };

    initial begin
        t_result want;
        regs[wbc_pkg::REG_HUE_MEAN] = 16'd0;     regs[wbc_pkg::REG_HUE_SPREAD] = 16'd256;
        regs[wbc_pkg::REG_SAT_MEAN] = 16'd0;     regs[wbc_pkg::REG_SAT_SPREAD] = 16'd256;
        regs[wbc_pkg::REG_VAL_MEAN] = 16'd0;     regs[wbc_pkg::REG_VAL_SPREAD] = 16'd256;
        regs[wbc_pkg::REG_STRICT_THR] = 16'd256; regs[wbc_pkg::REG_RELAX_THR] = 16'd256;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table under reset defaults; typed verdicts are checked too.
        foreach (directed[n]) begin
            if (directed[n].fixed) begin
                want = classify(directed[n].r, directed[n].g, directed[n].b, directed[n].mode);
                if (want.verdict != directed[n].verdict) begin
                    $error("verdict: expected %0d, got %0d", directed[n].verdict,
                           want.verdict);
                    mismatches++;
                end
            end
            send_block(directed[n].r, directed[n].g, directed[n].b, directed[n].mode);
        end
        drain_results();

        // Extreme settings: all zero (spreads treated as one), then all ones, then a random mix.
        for (int i = 0; i < 8; i++) write_reg(wbc_pkg::t_reg_idx'(i), 16'h0000);
        random_phase(100);
        drain_results();
        for (int i = 0; i < 8; i++) write_reg(wbc_pkg::t_reg_idx'(i), 16'hFFFF);
        random_phase(100);
        drain_results();
        random_settings(1'b1);
        random_phase(100);
        drain_results();

        // Plausible water statistics.
        for (int p = 0; p < 5; p++) begin
            random_settings(1'b0);
            random_phase(220);
            drain_results();
        end

        // Last stretch at full rate.
        quiet = 1'b1;
        random_settings(1'b0);
        random_phase(250);
        drain_results();

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
